[rtl/core/keyed_expiry_timer_table_core_assert.svh]
// Assertion macros shared by the timer table RTL.
// The enclosing module must provide the signals clk and rst_n.
`ifndef KEYED_EXPIRY_TIMER_TABLE_CORE_ASSERT_SVH
`define KEYED_EXPIRY_TIMER_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KET_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ketimer_pkg.sv]
// Shared types, widths and codes for the keyed expiry timer table.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package ketimer_pkg;

    localparam int ENTRIES_DEFAULT = 32;

    localparam int TIME_W    = 48;
    localparam int ID_W      = 32;
    localparam int TYPE_W    = 3;
    localparam int KEY_W     = ID_W + TYPE_W;
    localparam int TICKS_W   = 16;
    localparam int CMD_W     = 3;
    localparam int COUNT_W   = 6;
    localparam int REG_IDX_W = 3;
    localparam int NUM_REGS  = 7;

    localparam int COUNT_MAX = (2 ** COUNT_W) - 1;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd2000;

    // Command codes; unused codes behave as a query.
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START_DEF = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START_EXP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CANCEL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd5;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_SPELL  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POTION = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCROLL = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WEAPON = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_AMMO   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GEM    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FOOD   = 3'd6;

    // Source types that share the spell duration.
    localparam logic [TYPE_W-1:0] TYPE_SPELL     = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_SPELL_ALT = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic commit;
    } ketimer_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } ketimer_stat_t;

endpackage

`default_nettype wire

[rtl/core/ketimer_if.sv]
// Handshake channel interfaces for the keyed expiry timer table:
// command items, result items and configuration writes. Uses ketimer_pkg.
`default_nettype none

interface ketimer_in_if
    import ketimer_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    item_id;
    logic [TYPE_W-1:0]  source_type;
    logic [TICKS_W-1:0] explicit_ticks;

    modport source (output valid, cmd, item_id, source_type, explicit_ticks, input ready);
    modport sink   (input valid, cmd, item_id, source_type, explicit_ticks, output ready);
endinterface

interface ketimer_out_if
    import ketimer_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               active;
    logic [TICKS_W-1:0] remaining_ticks;
    logic [COUNT_W-1:0] active_count;
    logic               removed;
    logic               table_full;

    modport source (output valid, active, remaining_ticks, active_count, removed, table_full,
                    input ready);
    modport sink   (input valid, active, remaining_ticks, active_count, removed, table_full,
                    output ready);
endinterface

interface ketimer_cfg_if
    import ketimer_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [TICKS_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/ketimer_ctrl.sv]
// Sequencing controller for the timer table: accept, slot scan, drain, commit.
// Depends on ketimer_pkg; drives the datapath through ketimer_ctl_t.
`default_nettype none

module ketimer_ctrl
    import ketimer_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT,
    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ketimer_stat_t     stat,
    output ketimer_ctl_t           ctl,
    output logic [ADDR_W-1:0]      rd_addr
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        ctl.accept = (state_reg == ST_IDLE) && in_valid;
        ctl.rd_en  = (state_reg == ST_SCAN);
        ctl.commit = (state_reg == ST_COMMIT) && !stat.out_busy;
        rd_addr    = addr_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                    addr_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // Hold the commit until the result register can take the result.
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ketimer_dp.sv]
// Datapath of the timer table: duration registers, time counter, slot stores,
// scan accumulators and the result register. Depends on ketimer_pkg.
`default_nettype none

module ketimer_dp
    import ketimer_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT,
    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W  = $clog2(ENTRIES + 1)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [TICKS_W-1:0]   cfg_data,
    input  wire logic [CMD_W-1:0]     in_cmd,
    input  wire logic [ID_W-1:0]      in_item_id,
    input  wire logic [TYPE_W-1:0]    in_source_type,
    input  wire logic [TICKS_W-1:0]   in_explicit_ticks,
    input  wire ketimer_ctl_t         ctl,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output ketimer_stat_t             stat,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic                      out_active,
    output logic [TICKS_W-1:0]        out_remaining_ticks,
    output logic [COUNT_W-1:0]        out_active_count,
    output logic                      out_removed,
    output logic                      out_table_full
);

    localparam int SAT_W = CNT_W + 1 + COUNT_W;

    // Configuration and time base.
    logic [TICKS_W-1:0] cfg_ticks_reg [NUM_REGS];
    logic [TIME_W-1:0]  now_reg;
    logic [TICKS_W-1:0] dflt_ticks;

    // Current item.
    logic [CMD_W-1:0]   cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [TICKS_W-1:0] dur_reg;

    // Slot stores.
    logic [ENTRIES-1:0] valid_reg;
    logic [KEY_W-1:0]   key_mem [ENTRIES];
    logic [TIME_W-1:0]  exp_mem [ENTRIES];
    logic [KEY_W-1:0]   key_rd_reg;
    logic [TIME_W-1:0]  exp_rd_reg;
    logic               valid_rd_reg;
    logic               eval_reg;
    logic [ADDR_W-1:0]  eval_idx_reg;

    // Scan results.
    logic [CNT_W-1:0]   cnt_reg;
    logic               match_found_reg;
    logic [ADDR_W-1:0]  match_idx_reg;
    logic [TICKS_W-1:0] match_left_reg;
    logic               free_found_reg;
    logic [ADDR_W-1:0]  free_idx_reg;

    logic [TIME_W-1:0]  diff;
    logic               slot_act;

    logic               is_start;
    logic               started;
    logic               write_ok;
    logic               do_cancel;
    logic               do_clear;
    logic               match_act;
    logic [ADDR_W-1:0]  tgt_idx;
    logic [CNT_W:0]     cnt_after;
    logic [SAT_W-1:0]   cnt_wide;
    logic [TICKS_W-1:0] left_fin;

    logic               out_valid_reg;
    logic               out_active_reg;
    logic [TICKS_W-1:0] out_left_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_removed_reg;
    logic               out_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_ticks_reg[i] <= TICKS_RESET;
            end
        end
        else if (cfg_valid && (cfg_index < REG_IDX_W'(NUM_REGS)))
        begin
            cfg_ticks_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        case (in_source_type) inside
            TYPE_SPELL, TYPE_SPELL_ALT: dflt_ticks = cfg_ticks_reg[REG_SPELL];
            default:                    dflt_ticks = cfg_ticks_reg[in_source_type];
        endcase
    end

    // A tick advances time at acceptance, so the scan already sees the new time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
        end
        else if (ctl.accept && (in_cmd == CMD_TICK))
        begin
            now_reg <= now_reg + TIME_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg <= in_cmd;
            key_reg <= {in_item_id, in_source_type};
            dur_reg <= (in_cmd == CMD_START_DEF) ? dflt_ticks : in_explicit_ticks;
        end
    end

    // Slot memories: one write port at commit, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (ctl.commit && write_ok)
        begin
            key_mem[tgt_idx] <= key_reg;
            exp_mem[tgt_idx] <= now_reg + TIME_W'(dur_reg);
        end
        if (ctl.rd_en)
        begin
            key_rd_reg   <= key_mem[rd_addr];
            exp_rd_reg   <= exp_mem[rd_addr];
            valid_rd_reg <= valid_reg[rd_addr];
            eval_idx_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            eval_reg <= ctl.rd_en;
            if (ctl.commit)
            begin
                if (do_clear)
                begin
                    valid_reg <= '0;
                end
                else if (write_ok)
                begin
                    valid_reg[tgt_idx] <= 1'b1;
                end
                else if (do_cancel)
                begin
                    valid_reg[match_idx_reg] <= 1'b0;
                end
            end
        end
    end

    // A slot is live while its expiry lies 1 to 65535 ticks ahead, modulo the counter.
    always_comb
    begin
        diff     = exp_rd_reg - now_reg;
        slot_act = valid_rd_reg && (diff != '0) && (diff[TIME_W-1:TICKS_W] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cnt_reg         <= '0;
            match_found_reg <= 1'b0;
            match_left_reg  <= '0;
            free_found_reg  <= 1'b0;
        end
        else if (eval_reg)
        begin
            if (slot_act)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (!match_found_reg && valid_rd_reg && (key_rd_reg == key_reg))
            begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= eval_idx_reg;
                match_left_reg  <= slot_act ? diff[TICKS_W-1:0] : '0;
            end
            if (!free_found_reg && !slot_act)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= eval_idx_reg;
            end
        end
    end

    // A clear zeroes the count; else the scan count is corrected for the one slot touched.
    always_comb
    begin
        is_start  = (cmd_reg == CMD_START_DEF) || (cmd_reg == CMD_START_EXP);
        started   = is_start && (dur_reg != '0);
        write_ok  = started && (match_found_reg || free_found_reg);
        do_cancel = (cmd_reg == CMD_CANCEL) && match_found_reg;
        do_clear  = (cmd_reg == CMD_CLEAR);
        match_act = match_found_reg && (match_left_reg != '0);
        tgt_idx   = match_found_reg ? match_idx_reg : free_idx_reg;

        if (do_clear)
        begin
            cnt_after = '0;
        end
        else if (write_ok)
        begin
            cnt_after = {1'b0, cnt_reg} - (CNT_W + 1)'(match_act) + (CNT_W + 1)'(1);
        end
        else if (do_cancel)
        begin
            cnt_after = {1'b0, cnt_reg} - (CNT_W + 1)'(match_act);
        end
        else
        begin
            cnt_after = {1'b0, cnt_reg};
        end
        cnt_wide = SAT_W'(cnt_after);

        if (do_clear || (cmd_reg == CMD_CANCEL))
        begin
            left_fin = '0;
        end
        else if (write_ok)
        begin
            left_fin = dur_reg;
        end
        else
        begin
            left_fin = match_left_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            out_active_reg  <= (left_fin != '0);
            out_left_reg    <= left_fin;
            out_count_reg   <= (cnt_wide > SAT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                              : cnt_wide[COUNT_W-1:0];
            out_removed_reg <= do_cancel;
            out_full_reg    <= started && !write_ok;
        end
    end

    always_comb
    begin
        stat.out_busy       = out_valid_reg && !out_ready;
        out_valid           = out_valid_reg;
        out_active          = out_active_reg;
        out_remaining_ticks = out_left_reg;
        out_active_count    = out_count_reg;
        out_removed         = out_removed_reg;
        out_table_full      = out_full_reg;
    end

endmodule

`default_nettype wire

[rtl/core/keyed_expiry_timer_table_core.sv]
// Each command item is accepted only when the block is idle and, before the
// next one is accepted, passes in order through acceptance, a scan of one
// slot per cycle through the single read port of the key and expiry
// memories, a drain of the read register, and a commit of the command
// that loads the result into the result register.
// The result register is separate, so the next item is accepted while a
// result waits; a second result stalls the commit until the first is taken.
// Configuration writes are always accepted; there is no clearing pass.
// Top level: instantiates ketimer_ctrl and ketimer_dp; uses ketimer_pkg,
// the channel interfaces in ketimer_if.sv and the assertion macros.
`default_nettype none

`include "keyed_expiry_timer_table_core_assert.svh"

module keyed_expiry_timer_table_core
    import ketimer_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ketimer_in_if.sink  item,
    ketimer_out_if.source result,
    ketimer_cfg_if.sink cfg
);

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    ketimer_ctl_t      ctl;
    ketimer_stat_t     stat;
    logic [ADDR_W-1:0] rd_addr;

    assign cfg.ready = 1'b1;

    ketimer_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .stat     (stat),
        .ctl      (ctl),
        .rd_addr  (rd_addr)
    );

    ketimer_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg.valid),
        .cfg_index           (cfg.index),
        .cfg_data            (cfg.data),
        .in_cmd              (item.cmd),
        .in_item_id          (item.item_id),
        .in_source_type      (item.source_type),
        .in_explicit_ticks   (item.explicit_ticks),
        .ctl                 (ctl),
        .rd_addr             (rd_addr),
        .stat                (stat),
        .out_ready           (result.ready),
        .out_valid           (result.valid),
        .out_active          (result.active),
        .out_remaining_ticks (result.remaining_ticks),
        .out_active_count    (result.active_count),
        .out_removed         (result.removed),
        .out_table_full      (result.table_full)
    );

    `KET_ASSERT_SAME(a_result_from_commit, $rose(result.valid),
                     $past(ctl.commit), "result appeared without a commit")
    `KET_ASSERT_NEXT(a_one_item_at_a_time, item.valid && item.ready,
                     !item.ready, "item accepted while busy")
    `KET_ASSERT_SAME(a_commit_has_room, ctl.commit,
                     !result.valid || result.ready, "commit overwrote a pending result")
    `KET_ASSERT_SAME(a_active_has_time, result.valid && result.active,
                     result.remaining_ticks != '0, "active key with zero time left")

endmodule

`default_nettype wire
